[src/sombmu_pkg.sv]
// shared types, codes and the neighborhood falloff table for the som bmu block
`timescale 1ns / 1ps

package sombmu_pkg;

  // action codes of an input word
  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_READ     = 2'd1,
    ACT_CLASSIFY = 2'd2,
    ACT_TRAIN    = 2'd3
  } action_e;

  // sequencer states, one-hot
  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_ADDR     = 17'b00000000000000010,
    S_ACC      = 17'b00000000000000100,
    S_RDWAIT   = 17'b00000000000001000,
    S_SCAN_RD  = 17'b00000000000010000,
    S_SCAN_ACC = 17'b00000000000100000,
    S_TR_SETUP = 17'b00000000001000000,
    S_TR_BASE  = 17'b00000000010000000,
    S_TR_DX    = 17'b00000000100000000,
    S_TR_DY    = 17'b00000001000000000,
    S_TR_CHK   = 17'b00000010000000000,
    S_TR_DIV   = 17'b00000100000000000,
    S_TR_ROM   = 17'b00001000000000000,
    S_TR_GAIN  = 17'b00010000000000000,
    S_TR_RD    = 17'b00100000000000000,
    S_TR_MUL   = 17'b01000000000000000,
    S_TR_WR    = 17'b10000000000000000
  } state_e;

  localparam int unsigned NbEntries = 513;
  localparam logic [9:0]  IdxMax    = 10'd512;
  localparam logic [16:0] GainOne   = 17'd65536;

  typedef logic [0:NbEntries-1][16:0] nb_table_t;

  // exp(-i/76.8) in q1.16, built from a truncated taylor series of exp(-5/384)
  function automatic nb_table_t build_nb_table();
    nb_table_t   t;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] p;
    logic [63:0] prod;
    int          k;
    int          i;
    x    = ((64'd5 << 32) + 64'd192) / 64'd384;
    term = 64'd1 << 32;
    q    = term;
    p    = 64'd1 << 32;
    for (k = 1; k <= 7; k++) begin
      prod = term * x;
      term = (prod >> 32) / 64'(k);
      if (k[0]) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (i = 0; i < NbEntries; i++) begin
      t[i] = 17'((p + 64'd32768) >> 16);
      prod = p * q;
      p    = prod >> 32;
    end
    return t;
  endfunction

  localparam nb_table_t NbTable = build_nb_table();

endpackage

[src/som_bmu_search_and_update.sv]
// som best-matching-unit search and neighborhood training over an 8-bit weight grid
`timescale 1ns / 1ps

// usage
// - input channel (in_valid_i / in_ready_o) takes one word: an action plus its operands
// - output channel (out_valid_o / out_ready_i) returns exactly one word per input word
// - in_ready_o is high only while the sequencer is idle; one word is worked at a time
// - write: address multiply, then memory write; read: the same plus a read wait step
// - classify: a read step and an accumulate step per stored weight, then one closing step;
//   paced by the single memory port
// - train: the classify scan, setup (radius square, bounds), base address, then per in-grid
//   neighbor: distance, check, table, gain, and read, multiply, write per component, plus the
//   9-step restoring divider when the falloff index needs it; neighbors span offsets -R..R-1
// - all products but the scaling by COMPONENTS go through one shared 19x19 signed multiplier
// - the result sits in an output register; a finished word waits there while the
//   receiver stalls, and the sequencer holds in its last step until the slot frees
// - reset clears the sequencer and the output valid; weight memory is not cleared,
//   so weights read before being written are undefined
module som_bmu_search_and_update #(
  parameter int unsigned GRID_W     = 80,
  parameter int unsigned GRID_H     = 60,
  parameter int unsigned COMPONENTS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  cell_x_i,
  input  logic [7:0]  cell_y_i,
  input  logic [1:0]  component_index_i,
  input  logic [7:0]  weight_value_i,
  input  logic [7:0]  sample_a_i,
  input  logic [7:0]  sample_b_i,
  input  logic [7:0]  sample_c_i,
  input  logic [7:0]  sample_d_i,
  input  logic [7:0]  radius_i,
  input  logic [16:0] gain_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  bmu_x_o,
  output logic [7:0]  bmu_y_o,
  output logic [17:0] bmu_distance_o,
  output logic [7:0]  read_value_o,
  output logic        address_error_o
);

  localparam int unsigned Words   = GRID_W * GRID_H * COMPONENTS;
  localparam int unsigned AW      = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned ColStep = GRID_H * COMPONENTS;

  // sequencer
  sombmu_pkg::state_e state_q, state_d;

  // captured word
  sombmu_pkg::action_e act_q;
  logic [7:0]          cell_x_q;
  logic [7:0]          cell_y_q;
  logic [1:0]          comp_sel_q;
  logic [7:0]          wval_q;
  logic [3:0][7:0]     smp_q;
  logic [7:0]          radius_q;
  logic [16:0]         gain_q;

  // working registers
  logic [AW-1:0]  addr_q;
  logic [AW-1:0]  col_addr_q;
  logic [1:0]     comp_q;
  logic [7:0]     cx_q, cy_q;
  logic [17:0]    acc_q;
  logic [17:0]    best_q;
  logic [7:0]     bx_q, by_q;
  logic [7:0]     rd_q;
  logic [7:0]     rd_d;
  logic           err_q;
  logic [7:0]     x_lo_q, x_hi_q, y_lo_q, y_hi_q;
  logic [7:0]     tx_q, ty_q;
  logic [15:0]    r2_q;
  logic [16:0]    d2_q;
  logic [24:0]    num_q;
  logic [23:0]    dv_q;
  logic [3:0]     cnt_q;
  logic [7:0]     quo_q;
  logic [9:0]     idx_q;
  logic [16:0]    rom_q;
  logic [16:0]    s_q;
  logic [7:0]     nw_q;

  // output register
  logic        out_valid_q;
  logic [7:0]  bmu_x_q, bmu_y_q, read_value_q;
  logic [17:0] bmu_distance_q;
  logic        address_error_q;

  // weight memory
  logic [7:0]    mem_q [Words];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  // shared multiplier
  logic signed [18:0] mul_a, mul_b;
  logic signed [37:0] prod;

  logic        in_fire;
  logic        slot_free;
  logic [7:0]  smp_sel;
  logic signed [9:0] diff;
  logic signed [9:0] dx, dy;
  logic [17:0] cell_dist;
  logic        last_comp;
  logic        last_scan_cell;
  logic        access_err;
  logic [19:0] acc_addr;
  logic [19:0] base_addr;
  logic [8:0]  x_sum, y_sum;
  logic [7:0]  x_lo_c, x_hi_c, y_lo_c, y_hi_c;
  logic        div_ge;
  logic        far;

  assign in_ready_o = (state_q == sombmu_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign smp_sel   = smp_q[comp_q];
  assign diff      = $signed({2'b00, smp_sel}) - $signed({2'b00, rdata_q});
  assign dx        = $signed({2'b00, tx_q}) - $signed({2'b00, bx_q});
  assign dy        = $signed({2'b00, ty_q}) - $signed({2'b00, by_q});
  assign last_comp = (comp_q == 2'(COMPONENTS - 1));
  assign last_scan_cell = (cx_q == 8'(GRID_W - 1)) && (cy_q == 8'(GRID_H - 1));
  assign cell_dist = acc_q + 18'(prod[15:0]);

  // read data lands in the read wait step, the same step that may hand the word out
  assign rd_d = ((state_q == sombmu_pkg::S_RDWAIT) && (act_q == sombmu_pkg::ACT_READ)
                 && !err_q) ? rdata_q : rd_q;

  assign access_err = ({1'b0, cell_x_q} >= 9'(GRID_W)) || ({1'b0, cell_y_q} >= 9'(GRID_H))
                   || ({1'b0, comp_sel_q} >= 3'(COMPONENTS));
  // (x*H + y)*C + c, x*H from the multiplier
  assign acc_addr  = (20'(prod[16:0]) + 20'(cell_y_q)) * 20'(COMPONENTS) + 20'(comp_sel_q);
  assign base_addr = (20'(prod[16:0]) + 20'(y_lo_q)) * 20'(COMPONENTS);

  // neighborhood bounds clipped to the grid
  assign x_sum  = {1'b0, bx_q} + {1'b0, radius_q} - 9'd1;
  assign y_sum  = {1'b0, by_q} + {1'b0, radius_q} - 9'd1;
  assign x_lo_c = (bx_q >= radius_q) ? (bx_q - radius_q) : 8'd0;
  assign y_lo_c = (by_q >= radius_q) ? (by_q - radius_q) : 8'd0;
  assign x_hi_c = (x_sum >= 9'(GRID_W)) ? 8'(GRID_W - 1) : x_sum[7:0];
  assign y_hi_c = (y_sum >= 9'(GRID_H)) ? 8'(GRID_H - 1) : y_sum[7:0];

  // far neighbors clamp to the last table entry
  assign far    = (d2_q >= {r2_q, 1'b0});
  assign div_ge = (num_q >= {1'b0, dv_q});

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      sombmu_pkg::S_ADDR: begin
        mul_a = 19'(cell_x_q);
        mul_b = 19'(GRID_H);
      end
      sombmu_pkg::S_SCAN_ACC: begin
        mul_a = 19'(diff);
        mul_b = 19'(diff);
      end
      sombmu_pkg::S_TR_SETUP: begin
        mul_a = 19'(radius_q);
        mul_b = 19'(radius_q);
      end
      sombmu_pkg::S_TR_BASE: begin
        mul_a = 19'(x_lo_q);
        mul_b = 19'(GRID_H);
      end
      sombmu_pkg::S_TR_DX: begin
        mul_a = 19'(dx);
        mul_b = 19'(dx);
      end
      sombmu_pkg::S_TR_DY: begin
        mul_a = 19'(dy);
        mul_b = 19'(dy);
      end
      sombmu_pkg::S_TR_GAIN: begin
        mul_a = 19'(gain_q);
        mul_b = 19'(rom_q);
      end
      sombmu_pkg::S_TR_MUL: begin
        mul_a = 19'(diff);
        mul_b = 19'(s_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sombmu_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = action_i[1] ? sombmu_pkg::S_SCAN_RD : sombmu_pkg::S_ADDR;
        end
      end
      sombmu_pkg::S_ADDR: state_d = sombmu_pkg::S_ACC;
      sombmu_pkg::S_ACC: begin
        if (err_q || (act_q == sombmu_pkg::ACT_WRITE)) begin
          state_d = sombmu_pkg::S_IDLE;
        end else begin
          state_d = sombmu_pkg::S_RDWAIT;
        end
        if (err_q || (act_q == sombmu_pkg::ACT_WRITE)) begin
          state_d = slot_free ? sombmu_pkg::S_IDLE : sombmu_pkg::S_ACC;
        end
      end
      sombmu_pkg::S_RDWAIT: begin
        state_d = slot_free ? sombmu_pkg::S_IDLE : sombmu_pkg::S_RDWAIT;
      end
      sombmu_pkg::S_SCAN_RD: state_d = sombmu_pkg::S_SCAN_ACC;
      sombmu_pkg::S_SCAN_ACC: begin
        if (last_comp && last_scan_cell) begin
          if ((act_q == sombmu_pkg::ACT_TRAIN) && (radius_q != 8'd0)) begin
            state_d = sombmu_pkg::S_TR_SETUP;
          end else begin
            state_d = sombmu_pkg::S_RDWAIT;
          end
        end else begin
          state_d = sombmu_pkg::S_SCAN_RD;
        end
      end
      sombmu_pkg::S_TR_SETUP: state_d = sombmu_pkg::S_TR_BASE;
      sombmu_pkg::S_TR_BASE:  state_d = sombmu_pkg::S_TR_DX;
      sombmu_pkg::S_TR_DX:    state_d = sombmu_pkg::S_TR_DY;
      sombmu_pkg::S_TR_DY:    state_d = sombmu_pkg::S_TR_CHK;
      sombmu_pkg::S_TR_CHK: begin
        state_d = far ? sombmu_pkg::S_TR_ROM : sombmu_pkg::S_TR_DIV;
      end
      sombmu_pkg::S_TR_DIV: begin
        if (cnt_q == 4'd0) begin
          state_d = sombmu_pkg::S_TR_ROM;
        end
      end
      sombmu_pkg::S_TR_ROM:  state_d = sombmu_pkg::S_TR_GAIN;
      sombmu_pkg::S_TR_GAIN: state_d = sombmu_pkg::S_TR_RD;
      sombmu_pkg::S_TR_RD:   state_d = sombmu_pkg::S_TR_MUL;
      sombmu_pkg::S_TR_MUL:  state_d = sombmu_pkg::S_TR_WR;
      sombmu_pkg::S_TR_WR: begin
        if (!last_comp) begin
          state_d = sombmu_pkg::S_TR_RD;
        end else if ((tx_q == x_hi_q) && (ty_q == y_hi_q)) begin
          state_d = sombmu_pkg::S_RDWAIT;
        end else begin
          state_d = sombmu_pkg::S_TR_DX;
        end
      end
      default: state_d = sombmu_pkg::S_IDLE;
    endcase
  end

  // the result is taken in the step that leaves for idle
  logic finish;
  assign finish = (state_q != sombmu_pkg::S_IDLE) && (state_d == sombmu_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sombmu_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      bmu_x_q         <= bx_q;
      bmu_y_q         <= by_q;
      bmu_distance_q  <= act_q[1] ? best_q : 18'd0;
      read_value_q    <= rd_d;
      address_error_q <= err_q;
    end
  end

  // weight memory, one port, registered read
  assign mem_we    = ((state_q == sombmu_pkg::S_ACC) && !err_q
                      && (act_q == sombmu_pkg::ACT_WRITE))
                  || (state_q == sombmu_pkg::S_TR_WR);
  assign mem_wdata = (state_q == sombmu_pkg::S_ACC) ? wval_q : nw_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sombmu_pkg::S_IDLE: begin
        if (in_fire) begin
          act_q      <= sombmu_pkg::action_e'(action_i);
          cell_x_q   <= cell_x_i;
          cell_y_q   <= cell_y_i;
          comp_sel_q <= component_index_i;
          wval_q     <= weight_value_i;
          smp_q      <= {sample_d_i, sample_c_i, sample_b_i, sample_a_i};
          radius_q   <= radius_i;
          gain_q     <= (gain_i > sombmu_pkg::GainOne) ? sombmu_pkg::GainOne : gain_i;
          addr_q     <= '0;
          comp_q     <= 2'd0;
          cx_q       <= 8'd0;
          cy_q       <= 8'd0;
          acc_q      <= 18'd0;
          best_q     <= '1;
          bx_q       <= 8'd0;
          by_q       <= 8'd0;
          rd_q       <= 8'd0;
          err_q      <= 1'b0;
        end
      end
      sombmu_pkg::S_ADDR: begin
        err_q  <= access_err;
        addr_q <= AW'(acc_addr);
      end
      sombmu_pkg::S_ACC: begin
        rd_q <= rd_q;
      end
      sombmu_pkg::S_RDWAIT: begin
        // only a weight read lands here with fresh memory data in flight
        rd_q <= rd_d;
      end
      sombmu_pkg::S_SCAN_RD: begin
        acc_q <= acc_q;
      end
      sombmu_pkg::S_SCAN_ACC: begin
        addr_q <= addr_q + AW'(1);
        if (last_comp) begin
          // strict less-than keeps the first minimum in scan order
          if (cell_dist < best_q) begin
            best_q <= cell_dist;
            bx_q   <= cx_q;
            by_q   <= cy_q;
          end
          acc_q  <= 18'd0;
          comp_q <= 2'd0;
          if (cy_q == 8'(GRID_H - 1)) begin
            cy_q <= 8'd0;
            cx_q <= cx_q + 8'd1;
          end else begin
            cy_q <= cy_q + 8'd1;
          end
        end else begin
          acc_q  <= cell_dist;
          comp_q <= comp_q + 2'd1;
        end
      end
      sombmu_pkg::S_TR_SETUP: begin
        r2_q   <= prod[15:0];
        x_lo_q <= x_lo_c;
        x_hi_q <= x_hi_c;
        y_lo_q <= y_lo_c;
        y_hi_q <= y_hi_c;
        tx_q   <= x_lo_c;
        ty_q   <= y_lo_c;
        comp_q <= 2'd0;
      end
      sombmu_pkg::S_TR_BASE: begin
        addr_q     <= AW'(base_addr);
        col_addr_q <= AW'(base_addr);
      end
      sombmu_pkg::S_TR_DX: begin
        d2_q <= 17'(prod[15:0]);
      end
      sombmu_pkg::S_TR_DY: begin
        d2_q <= d2_q + 17'(prod[15:0]);
      end
      sombmu_pkg::S_TR_CHK: begin
        idx_q <= sombmu_pkg::IdxMax;
        num_q <= {d2_q, 8'd0};
        dv_q  <= {r2_q, 8'd0};
        cnt_q <= 4'd8;
        quo_q <= 8'd0;
      end
      sombmu_pkg::S_TR_DIV: begin
        // restoring division, one quotient bit a cycle, msb first
        if (div_ge) begin
          num_q <= num_q - {1'b0, dv_q};
        end
        dv_q  <= dv_q >> 1;
        quo_q <= {quo_q[6:0], div_ge};
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          idx_q <= {quo_q, div_ge} > 9'(0) ? {1'b0, quo_q, div_ge} : 10'd0;
        end
      end
      sombmu_pkg::S_TR_ROM: begin
        rom_q <= sombmu_pkg::NbTable[idx_q];
      end
      sombmu_pkg::S_TR_GAIN: begin
        s_q <= prod[32:16];
      end
      sombmu_pkg::S_TR_RD: begin
        nw_q <= nw_q;
      end
      sombmu_pkg::S_TR_MUL: begin
        // w + floor((x - w) * s / 2^16)
        nw_q <= rdata_q + prod[23:16];
      end
      sombmu_pkg::S_TR_WR: begin
        if (!last_comp) begin
          comp_q <= comp_q + 2'd1;
          addr_q <= addr_q + AW'(1);
        end else begin
          comp_q <= 2'd0;
          if (ty_q == y_hi_q) begin
            ty_q       <= y_lo_q;
            tx_q       <= tx_q + 8'd1;
            col_addr_q <= col_addr_q + AW'(ColStep);
            addr_q     <= col_addr_q + AW'(ColStep);
          end else begin
            ty_q   <= ty_q + 8'd1;
            addr_q <= addr_q + AW'(1);
          end
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign bmu_x_o         = bmu_x_q;
  assign bmu_y_o         = bmu_y_q;
  assign bmu_distance_o  = bmu_distance_q;
  assign read_value_o    = read_value_q;
  assign address_error_o = address_error_q;

  // a taken word makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("block still ready after taking a word");

  // an address error never comes with search or read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && address_error_o) |-> (read_value_o == 8'd0 && bmu_distance_o == 18'd0))
    else $error("address error reported with data");

  // training only writes cells inside the clipped neighborhood
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sombmu_pkg::S_TR_WR) |-> (tx_q >= x_lo_q && tx_q <= x_hi_q
                                         && ty_q >= y_lo_q && ty_q <= y_hi_q))
    else $error("training write outside neighborhood");

endmodule
